[rtl/amqp_frame_parser_defines.svh]
// Assertion macros shared by the checker of the AMQP frame parser.
// Depends on nothing; included by the checker file.
`ifndef AMQP_FRAME_PARSER_DEFINES_SVH
`define AMQP_FRAME_PARSER_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define AFP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define AFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/afp_pkg.sv]
// Types and constants of the AMQP 0-9-1 frame parser.
// Depends on nothing; used by every module of the parser.
package afp_pkg;
	localparam logic [7:0] FRAME_END = 8'hCE;
	localparam logic [7:0] FT_METHOD = 8'h01;
	localparam logic [7:0] FT_HEADER = 8'h02;
	localparam logic [7:0] FT_BODY = 8'h03;
	localparam logic [7:0] FT_HEARTBEAT = 8'h08;
	localparam logic [15:0] CLS_CONNECTION = 16'd10;
	localparam logic [15:0] CLS_BASIC = 16'd60;
	localparam logic [15:0] MTH_TUNE = 16'd30;
	localparam logic [15:0] MTH_OPEN = 16'd40;
	localparam logic [15:0] MTH_PUBLISH = 16'd40;
	localparam logic [15:0] MTH_DELIVER = 16'd60;
	localparam logic [15:0] MTH_ACK = 16'd80;

	localparam logic [2:0] KIND_PROTO = 3'd0;
	localparam logic [2:0] KIND_METHOD = 3'd1;
	localparam logic [2:0] KIND_HEADER = 3'd2;
	localparam logic [2:0] KIND_BODY = 3'd3;
	localparam logic [2:0] KIND_HEARTBEAT = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_END = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_SHORT = 3'd3;
	localparam logic [2:0] ST_BAD_HB = 3'd4;

	localparam int RES_W = 3 + 3 + 16 + 16 + 16 + 64 + 16 + 32 + 16 + 8 + 8 + 2;
	// The frame kind travels in tuser; every other field goes to tdata.
	localparam int DATA_W = RES_W - 3;
	localparam int DATA_BYTES = (DATA_W + 7) / 8;

	typedef struct packed {
		logic [1:0] publish_flags;
		logic [7:0] second_name_length;
		logic [7:0] first_name_length;
		logic [15:0] heartbeat;
		logic [31:0] size_limit;
		logic [15:0] chan_limit;
		logic [63:0] tag_or_size;
		logic [15:0] mth_code;
		logic [15:0] cls_code;
		logic [15:0] channel;
		logic [2:0] status;
		logic [2:0] frame_kind;
	} result_t;

	// Frame snapshot handed from the byte parser to the result stage.
	typedef struct packed {
		logic proto;
		logic [7:0] end_byte;
		logic [7:0] ftype;
		logic [15:0] channel;
		logic [31:0] plen;
		logic [15:0] cls_code;
		logic [15:0] mth_code;
		logic [63:0] tag;
		logic [63:0] tune;
		logic [7:0] len1;
		logic [7:0] len2;
		logic [7:0] lenc;
		logic [1:0] flags;
	} frame_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_PROTO = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_END = 4'b1000
	} phase_t;
endpackage

[rtl/afp_front.sv]
// Byte parser: follows the frame structure and gathers the decoded fields.
// Depends on afp_pkg; emits one frame snapshot per unit to the queue.
module afp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] in_byte,
	output logic in_ready,
	output logic snap_valid,
	output afp_pkg::frame_t snap,
	input logic snap_ready
);
	import afp_pkg::*;

	phase_t phase_q;
	logic [31:0] pos_q;
	logic [7:0] ftype_q;
	logic [15:0] chan_q;
	logic [31:0] plen_q;
	logic [15:0] cls_q;
	logic [15:0] mth_q;
	logic [63:0] tag_q;
	logic [63:0] tune_q;
	logic [7:0] len1_q;
	logic [7:0] len2_q;
	logic [7:0] lenc_q;
	logic [1:0] flags_q;
	// Precomputed offsets of the publish and deliver fields.
	logic [8:0] off_rk_q;
	logic [9:0] off_fl_q;
	logic [8:0] off_dt_q;

	logic take;
	logic is_tune, is_open, is_pub, is_del, is_ack;
	logic [31:0] pos_inc;

	// A byte that closes a unit needs room in the queue; others never stall.
	logic closes;
	assign closes = (phase_q == PH_END) || (phase_q == PH_PROTO && pos_q[1:0] == 2'd3);
	assign in_ready = !closes || snap_ready;
	assign take = in_valid && in_ready;
	assign snap_valid = in_valid && closes;
	assign pos_inc = pos_q + 32'd1;

	assign is_tune = cls_q == CLS_CONNECTION && mth_q == MTH_TUNE;
	assign is_open = cls_q == CLS_CONNECTION && mth_q == MTH_OPEN;
	assign is_pub = cls_q == CLS_BASIC && mth_q == MTH_PUBLISH;
	assign is_del = cls_q == CLS_BASIC && mth_q == MTH_DELIVER;
	assign is_ack = cls_q == CLS_BASIC && mth_q == MTH_ACK;

	always_comb begin
		snap = '0;
		snap.proto = (phase_q == PH_PROTO);
		snap.end_byte = in_byte;
		snap.ftype = ftype_q;
		snap.channel = chan_q;
		snap.plen = plen_q;
		snap.cls_code = cls_q;
		snap.mth_code = mth_q;
		snap.tag = tag_q;
		snap.tune = tune_q;
		snap.len1 = len1_q;
		snap.len2 = len2_q;
		snap.lenc = lenc_q;
		snap.flags = flags_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			ftype_q <= '0;
			chan_q <= '0;
			plen_q <= '0;
			cls_q <= '0;
			mth_q <= '0;
			tag_q <= '0;
			tune_q <= '0;
			len1_q <= '0;
			len2_q <= '0;
			lenc_q <= '0;
			flags_q <= '0;
			off_rk_q <= '0;
			off_fl_q <= '0;
			off_dt_q <= '0;
		end else if (take) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q == 32'd0) begin
						ftype_q <= in_byte;
						chan_q <= '0;
						plen_q <= '0;
						cls_q <= '0;
						mth_q <= '0;
						tag_q <= '0;
						tune_q <= '0;
						len1_q <= '0;
						len2_q <= '0;
						lenc_q <= '0;
						flags_q <= '0;
						pos_q <= pos_inc;
					end else if (pos_q == 32'd3 && ftype_q == 8'h41 && chan_q == 16'h4D51
							&& in_byte == 8'h50) begin
						plen_q <= {plen_q[23:0], in_byte};
						phase_q <= PH_PROTO;
						pos_q <= '0;
					end else begin
						if (pos_q < 32'd3) begin
							chan_q <= {chan_q[7:0], in_byte};
						end else begin
							plen_q <= {plen_q[23:0], in_byte};
						end
						if (pos_q == 32'd6) begin
							pos_q <= '0;
							phase_q <= ({plen_q[23:0], in_byte} == 32'd0) ? PH_END : PH_PAYLOAD;
						end else begin
							pos_q <= pos_inc;
						end
					end
				end
				PH_PROTO: begin
					if (pos_q[1:0] == 2'd3) begin
						phase_q <= PH_HEADER;
						pos_q <= '0;
						chan_q <= '0;
					end else begin
						pos_q <= pos_inc;
					end
				end
				PH_PAYLOAD: begin
					if (ftype_q == FT_HEADER) begin
						if (pos_q < 32'd2) cls_q <= {cls_q[7:0], in_byte};
						else if (pos_q >= 32'd4 && pos_q < 32'd12) tag_q <= {tag_q[55:0], in_byte};
					end else if (ftype_q == FT_METHOD) begin
						if (pos_q < 32'd2) begin
							cls_q <= {cls_q[7:0], in_byte};
						end else if (pos_q < 32'd4) begin
							mth_q <= {mth_q[7:0], in_byte};
						end else if (is_tune) begin
							if (pos_q < 32'd12) tune_q <= {tune_q[55:0], in_byte};
						end else if (is_open) begin
							if (pos_q == 32'd4) len1_q <= in_byte;
						end else if (is_pub) begin
							if (pos_q == 32'd6) begin
								len1_q <= in_byte;
								off_rk_q <= 9'd7 + {1'b0, in_byte};
							end else if (pos_q == {23'd0, off_rk_q}) begin
								len2_q <= in_byte;
								off_fl_q <= {1'b0, off_rk_q} + 10'd1 + {2'd0, in_byte};
							end else if (pos_q == {22'd0, off_fl_q}) begin
								flags_q <= in_byte[1:0];
							end
						end else if (is_del) begin
							if (pos_q == 32'd4) begin
								lenc_q <= in_byte;
								off_dt_q <= 9'd5 + {1'b0, in_byte};
							end else if (pos_q >= {23'd0, off_dt_q}
									&& pos_q < {23'd0, off_dt_q} + 32'd8) begin
								tag_q <= {tag_q[55:0], in_byte};
							end
						end else if (is_ack) begin
							if (pos_q < 32'd12) tag_q <= {tag_q[55:0], in_byte};
						end
					end
					pos_q <= pos_inc;
					if (pos_inc >= plen_q) phase_q <= PH_END;
				end
				PH_END: begin
					phase_q <= PH_HEADER;
					pos_q <= '0;
				end
				default: begin
					phase_q <= PH_HEADER;
					pos_q <= '0;
				end
			endcase
		end
	end
endmodule

[rtl/afp_queue.sv]
// Two-entry queue of frame snapshots between the byte parser and result stage.
// Depends on afp_pkg.
module afp_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	input afp_pkg::frame_t wr_data,
	output logic wr_ready,
	output logic rd_valid,
	output afp_pkg::frame_t rd_data,
	input logic rd_ready
);
	import afp_pkg::*;

	frame_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

[rtl/afp_back.sv]
// Result stage: checks the frame, builds the result word and holds it.
// Depends on afp_pkg.
module afp_back (
	input logic clk,
	input logic arst_n,
	input logic snap_valid,
	input afp_pkg::frame_t snap,
	output logic snap_ready,
	output logic res_valid,
	output afp_pkg::result_t res,
	input logic res_ready
);
	import afp_pkg::*;

	logic [8:0] need_open;
	logic [9:0] need_pub;
	logic [8:0] need_del;
	logic tune, open, pub, del, ack;
	result_t r;
	result_t res_q;
	logic valid_q;

	assign snap_ready = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res = res_q;

	assign tune = snap.cls_code == CLS_CONNECTION && snap.mth_code == MTH_TUNE;
	assign open = snap.cls_code == CLS_CONNECTION && snap.mth_code == MTH_OPEN;
	assign pub = snap.cls_code == CLS_BASIC && snap.mth_code == MTH_PUBLISH;
	assign del = snap.cls_code == CLS_BASIC && snap.mth_code == MTH_DELIVER;
	assign ack = snap.cls_code == CLS_BASIC && snap.mth_code == MTH_ACK;
	assign need_open = 9'd5 + {1'b0, snap.len1};
	assign need_pub = 10'd9 + {2'd0, snap.len1} + {2'd0, snap.len2};
	assign need_del = 9'd13 + {1'b0, snap.lenc};

	always_comb begin
		r = '0;
		if (snap.proto) begin
			r.frame_kind = KIND_PROTO;
		end else begin
			r.channel = snap.channel;
			case (snap.ftype)
				FT_METHOD: r.frame_kind = KIND_METHOD;
				FT_HEADER: r.frame_kind = KIND_HEADER;
				FT_BODY: r.frame_kind = KIND_BODY;
				FT_HEARTBEAT: r.frame_kind = KIND_HEARTBEAT;
				default: r.frame_kind = KIND_PROTO;
			endcase
			if (snap.end_byte != FRAME_END) begin
				r.status = ST_BAD_END;
			end else if (snap.ftype == FT_METHOD) begin
				if (snap.plen < 32'd4
						|| (tune && snap.plen < 32'd12)
						|| (open && snap.plen < {23'd0, need_open})
						|| (pub && snap.plen < {22'd0, need_pub})
						|| (del && snap.plen < {23'd0, need_del})
						|| (ack && snap.plen < 32'd12))
					r.status = ST_SHORT;
			end else if (snap.ftype == FT_HEADER) begin
				if (snap.plen < 32'd12) r.status = ST_SHORT;
			end else if (snap.ftype == FT_HEARTBEAT) begin
				if (snap.plen != 32'd0) r.status = ST_BAD_HB;
			end else if (snap.ftype != FT_BODY) begin
				r.status = ST_UNKNOWN;
			end
			if (r.status == ST_OK) begin
				if (snap.ftype == FT_HEADER) begin
					r.cls_code = snap.cls_code;
					r.tag_or_size = snap.tag;
				end else if (snap.ftype == FT_METHOD) begin
					r.cls_code = snap.cls_code;
					r.mth_code = snap.mth_code;
					if (tune) begin
						r.chan_limit = snap.tune[63:48];
						r.size_limit = snap.tune[47:16];
						r.heartbeat = snap.tune[15:0];
					end else if (open) begin
						r.first_name_length = snap.len1;
					end else if (pub) begin
						r.first_name_length = snap.len1;
						r.second_name_length = snap.len2;
						r.publish_flags = snap.flags;
					end else if (del || ack) begin
						r.tag_or_size = snap.tag;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (snap_ready) begin
			valid_q <= snap_valid;
		end
	end
endmodule

[rtl/amqp_frame_parser.sv]
// AMQP 0-9-1 frame parser top level.
// Depends on afp_pkg, afp_front, afp_queue and afp_back.
//
// The slave side takes one byte of the stream per word (s_axis_tdata).
// The master side gives one word per protocol header or frame, on the
// word that carries its last byte, with the frame kind in m_axis_tuser
// and the decoded fields in m_axis_tdata (see the port comments).
// Throughput is one byte per cycle while the slave side is not stalled. The
// snapshot of a closing byte is written into the snapshot queue as the byte
// is taken, then into the output register, from which its result word is
// offered. The front parser decodes every byte as it is taken; only a
// closing byte needs a free queue slot, so the slave side stalls only while
// the queue holds two snapshots, which happens only after the sink has held
// the output register.
// Reset clears the parser to wait for the start of a unit and empties the
// queue and the output register.
module amqp_frame_parser (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // data_byte
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status, channel, cls_code, mth_code, tag_or_size, chan_limit,
	// size_limit, heartbeat, first_name_length, second_name_length,
	// publish_flags, then zero padding
	output logic [8*afp_pkg::DATA_BYTES-1:0] m_axis_tdata,
	output logic [2:0] m_axis_tuser // frame_kind
);
	import afp_pkg::*;

	logic f_valid, f_ready, b_valid, b_ready;
	frame_t f_snap, b_snap;
	result_t res;

	afp_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_byte(s_axis_tdata), .in_ready(s_axis_tready),
		.snap_valid(f_valid), .snap(f_snap), .snap_ready(f_ready)
	);

	afp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_data(f_snap), .wr_ready(f_ready),
		.rd_valid(b_valid), .rd_data(b_snap), .rd_ready(b_ready)
	);

	afp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.snap_valid(b_valid), .snap(b_snap), .snap_ready(b_ready),
		.res_valid(m_axis_tvalid), .res(res), .res_ready(m_axis_tready)
	);

	assign m_axis_tuser = res.frame_kind;
	assign m_axis_tdata = {{(8*DATA_BYTES-DATA_W){1'b0}}, res[RES_W-1:3]};
endmodule

[rtl/amqp_frame_parser_checker.sv]
// Port checker for the AMQP frame parser, bound to the top level.
// Depends on amqp_frame_parser_defines.svh and afp_pkg.
`include "amqp_frame_parser_defines.svh"
module amqp_frame_parser_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [8*afp_pkg::DATA_BYTES-1:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser
);
	`AFP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`AFP_ASSERT_IMP(a_ready_known, s_axis_tvalid, !$isunknown(s_axis_tready))
	`AFP_ASSERT_IMP(a_kind_range, m_axis_tvalid, m_axis_tuser <= 3'd4)
	`AFP_ASSERT_IMP(a_status_range, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd4)
	`AFP_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tdata[2:0] != 3'd0,
		m_axis_tdata[196:19] == '0)
endmodule

bind amqp_frame_parser amqp_frame_parser_checker u_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

[tb/amqp_frame_parser_checker.sv]
// Checker for the AMQP frame parser: watches both streams, predicts each
// result from the accepted bytes and compares field by field. Depends on afp_pkg.
module afp_tb_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [8*afp_pkg::DATA_BYTES-1:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser,
	output int fail_count,
	output int pending,
	output int results_seen,
	output int errors_seen
);
	import afp_pkg::*;

	typedef enum logic [1:0] {P_HDR, P_PROTO, P_PAY, P_END} pphase_t;

	pphase_t phase;
	logic [31:0] pos;
	logic [7:0] ftype;
	logic [15:0] chan;
	logic [31:0] plen;
	logic [15:0] cls;
	logic [15:0] mth;
	logic [63:0] tag;
	logic [63:0] tune;
	logic [7:0] len1, len2, lenc;
	logic [1:0] flags;
	result_t expected_results[$];

	function automatic logic is_m(logic [15:0] c, logic [15:0] m);
		return cls == c && mth == m;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		fail_count++;
	endtask

	// Decodes one payload byte at offset o.
	task automatic take_byte(logic [31:0] o, logic [7:0] b);
		if (ftype == FT_HEADER) begin
			if (o < 2) cls = {cls[7:0], b};
			else if (o >= 4 && o < 12) tag = {tag[55:0], b};
		end else if (ftype == FT_METHOD) begin
			if (o < 2) cls = {cls[7:0], b};
			else if (o < 4) mth = {mth[7:0], b};
			else if (is_m(CLS_CONNECTION, MTH_TUNE)) begin
				if (o < 12) tune = {tune[55:0], b};
			end else if (is_m(CLS_CONNECTION, MTH_OPEN)) begin
				if (o == 4) len1 = b;
			end else if (is_m(CLS_BASIC, MTH_PUBLISH)) begin
				if (o == 6) len1 = b;
				else if (o == 7 + len1) len2 = b;
				else if (o == 8 + len1 + len2) flags = b[1:0];
			end else if (is_m(CLS_BASIC, MTH_DELIVER)) begin
				if (o == 4) lenc = b;
				else if (o >= 5 + lenc && o < 13 + lenc) tag = {tag[55:0], b};
			end else if (is_m(CLS_BASIC, MTH_ACK)) begin
				if (o < 12) tag = {tag[55:0], b};
			end
		end
	endtask

	function automatic result_t close_frame(logic [7:0] b);
		result_t r;
		r = '0;
		case (ftype)
			FT_METHOD: r.frame_kind = KIND_METHOD;
			FT_HEADER: r.frame_kind = KIND_HEADER;
			FT_BODY: r.frame_kind = KIND_BODY;
			FT_HEARTBEAT: r.frame_kind = KIND_HEARTBEAT;
			default: r.frame_kind = KIND_PROTO;
		endcase
		r.status = ST_OK;
		if (b != FRAME_END) r.status = ST_BAD_END;
		else if (ftype == FT_METHOD) begin
			if (plen < 4 ||
					(is_m(CLS_CONNECTION, MTH_TUNE) && plen < 12) ||
					(is_m(CLS_CONNECTION, MTH_OPEN) && plen < 5 + len1) ||
					(is_m(CLS_BASIC, MTH_PUBLISH) && plen < 9 + len1 + len2) ||
					(is_m(CLS_BASIC, MTH_DELIVER) && plen < 13 + lenc) ||
					(is_m(CLS_BASIC, MTH_ACK) && plen < 12))
				r.status = ST_SHORT;
		end else if (ftype == FT_HEADER) begin
			if (plen < 12) r.status = ST_SHORT;
		end else if (ftype == FT_HEARTBEAT) begin
			if (plen != 0) r.status = ST_BAD_HB;
		end else if (ftype != FT_BODY) r.status = ST_UNKNOWN;
		r.channel = chan;
		if (r.status != ST_OK) return r;
		if (ftype == FT_HEADER) begin
			r.cls_code = cls;
			r.tag_or_size = tag;
		end else if (ftype == FT_METHOD) begin
			r.cls_code = cls;
			r.mth_code = mth;
			if (is_m(CLS_CONNECTION, MTH_TUNE)) begin
				r.chan_limit = tune[63:48];
				r.size_limit = tune[47:16];
				r.heartbeat = tune[15:0];
			end else if (is_m(CLS_CONNECTION, MTH_OPEN)) r.first_name_length = len1;
			else if (is_m(CLS_BASIC, MTH_PUBLISH)) begin
				r.first_name_length = len1;
				r.second_name_length = len2;
				r.publish_flags = flags;
			end else if (is_m(CLS_BASIC, MTH_DELIVER) || is_m(CLS_BASIC, MTH_ACK))
				r.tag_or_size = tag;
		end
		return r;
	endfunction

	task automatic predict_byte(logic [7:0] b);
		result_t r;
		case (phase)
			P_HDR: begin
				if (pos == 0) begin
					ftype = b; chan = '0; plen = '0; cls = '0; mth = '0;
					tag = '0; tune = '0; len1 = '0; len2 = '0; lenc = '0; flags = '0;
				end else if (pos < 3) chan = {chan[7:0], b};
				else plen = {plen[23:0], b};
				if (pos == 3 && ftype == 8'h41 && chan == 16'h4D51 && b == 8'h50) begin
					phase = P_PROTO;
					pos = 0;
				end else if (pos + 1 >= 7) begin
					pos = 0;
					phase = (plen == 0) ? P_END : P_PAY;
				end else pos++;
			end
			P_PROTO: begin
				pos++;
				if (pos >= 4) begin
					phase = P_HDR;
					pos = 0;
					r = '0;
					r.frame_kind = KIND_PROTO;
					expected_results.push_back(r);
				end
			end
			P_PAY: begin
				take_byte(pos, b);
				pos++;
				if (pos >= plen) phase = P_END;
			end
			default: begin
				expected_results.push_back(close_frame(b));
				phase = P_HDR;
				pos = 0;
			end
		endcase
	endtask

	task automatic compare(result_t g);
		result_t w;
		results_seen++;
		if (expected_results.size() == 0) begin
			report("word with nothing expected", 64'(g.status), 64'(0));
			return;
		end
		w = expected_results.pop_front();
		if (w.status != ST_OK) errors_seen++;
		if (g.frame_kind !== w.frame_kind)
			report("frame_kind", 64'(g.frame_kind), 64'(w.frame_kind));
		if (g.status !== w.status) report("status", 64'(g.status), 64'(w.status));
		if (g.channel !== w.channel) report("channel", 64'(g.channel), 64'(w.channel));
		if (g.cls_code !== w.cls_code) report("cls_code", 64'(g.cls_code), 64'(w.cls_code));
		if (g.mth_code !== w.mth_code) report("mth_code", 64'(g.mth_code), 64'(w.mth_code));
		if (g.tag_or_size !== w.tag_or_size)
			report("tag_or_size", g.tag_or_size, w.tag_or_size);
		if (g.chan_limit !== w.chan_limit)
			report("chan_limit", 64'(g.chan_limit), 64'(w.chan_limit));
		if (g.size_limit !== w.size_limit)
			report("size_limit", 64'(g.size_limit), 64'(w.size_limit));
		if (g.heartbeat !== w.heartbeat)
			report("heartbeat", 64'(g.heartbeat), 64'(w.heartbeat));
		if (g.first_name_length !== w.first_name_length)
			report("first_name_length", 64'(g.first_name_length), 64'(w.first_name_length));
		if (g.second_name_length !== w.second_name_length)
			report("second_name_length", 64'(g.second_name_length),
				64'(w.second_name_length));
		if (g.publish_flags !== w.publish_flags)
			report("publish_flags", 64'(g.publish_flags), 64'(w.publish_flags));
		if (m_axis_tdata[8*DATA_BYTES-1:DATA_W] !== '0)
			report("padding", 64'(m_axis_tdata[8*DATA_BYTES-1:DATA_W]), 64'(0));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = P_HDR;
			pos = '0;
			ftype = '0; chan = '0; plen = '0; cls = '0; mth = '0;
			tag = '0; tune = '0; len1 = '0; len2 = '0; lenc = '0; flags = '0;
			fail_count = 0;
			results_seen = 0;
			errors_seen = 0;
			expected_results.delete();
		end else begin
			// The output word is compared before this edge's byte is predicted;
			// a result can never come out in the cycle its closing byte is taken.
			if (m_axis_tvalid && m_axis_tready)
				compare(result_t'({m_axis_tdata[DATA_W-1:0], m_axis_tuser}));
			if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata);
		end
	end

	assign pending = expected_results.size();
endmodule

[tb/tb.sv]
// Top of the AMQP frame parser testbench: drives the byte stream with bursts
// and gaps, stalls the result side, and gives the verdict. Depends on afp_pkg.
module tb;
	import afp_pkg::*;

	localparam int WATCHDOG = 5000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [8*DATA_BYTES-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	int fail_count, pending, results_seen, errors_seen;
	int idle_cycles = 0;
	int bytes_sent;
	logic [7:0] stream_bytes[$];

	amqp_frame_parser i_dut (.*);

	afp_tb_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The result side stalls in runs of random length, with stall-free stretches.
	initial begin
		int mode;
		m_axis_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(1, 40)) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= 1'($urandom_range(0, 1));
					default: m_axis_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic put_frame(logic [7:0] ft, logic [15:0] ch, logic [7:0] pay[$],
			logic [7:0] end_byte);
		logic [31:0] n;
		n = pay.size();
		stream_bytes.push_back(ft);
		stream_bytes.push_back(ch[15:8]);
		stream_bytes.push_back(ch[7:0]);
		for (int i = 3; i >= 0; i--) stream_bytes.push_back(n[8*i +: 8]);
		foreach (pay[i]) stream_bytes.push_back(pay[i]);
		stream_bytes.push_back(end_byte);
	endtask

	task automatic put_proto();
		stream_bytes.push_back("A");
		stream_bytes.push_back("M");
		stream_bytes.push_back("Q");
		stream_bytes.push_back("P");
		repeat (4) stream_bytes.push_back(8'($urandom));
	endtask

	function automatic void push_rand(ref logic [7:0] q[$], input int n);
		repeat (n) q.push_back(8'($urandom));
	endfunction

	// Builds a method payload for class c and method m, with name lengths
	// l1 and l2 and the total payload trimmed or padded by trim bytes.
	function automatic void method_payload(ref logic [7:0] q[$], input logic [15:0] c,
			input logic [15:0] m, input int l1, input int l2, input int trim);
		q = {};
		q.push_back(c[15:8]); q.push_back(c[7:0]);
		q.push_back(m[15:8]); q.push_back(m[7:0]);
		if (c == CLS_CONNECTION && m == MTH_TUNE) push_rand(q, 8);
		else if (c == CLS_CONNECTION && m == MTH_OPEN) begin
			q.push_back(8'(l1)); push_rand(q, l1);
		end else if (c == CLS_BASIC && m == MTH_PUBLISH) begin
			push_rand(q, 2); q.push_back(8'(l1)); push_rand(q, l1);
			q.push_back(8'(l2)); push_rand(q, l2); q.push_back(8'($urandom));
		end else if (c == CLS_BASIC && m == MTH_DELIVER) begin
			q.push_back(8'(l1)); push_rand(q, l1); push_rand(q, 8);
		end else if (c == CLS_BASIC && m == MTH_ACK) push_rand(q, 8);
		if (trim > 0) push_rand(q, trim);
		else repeat (-trim) if (q.size() > 0) void'(q.pop_back());
	endfunction

	task automatic random_unit(logic [7:0] pay[$]);
		int k;
		logic [7:0] endb;
		logic [15:0] ch;
		k = $urandom_range(0, 19);
		endb = ($urandom_range(0, 15) == 0) ? 8'($urandom) : FRAME_END;
		ch = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		if (k == 0) put_proto();
		else if (k < 3) begin
			pay = {};
			push_rand(pay, $urandom_range(0, 10));
			put_frame($urandom_range(0, 1) ? FT_BODY : 8'($urandom), ch, pay, endb);
		end else if (k == 3) begin
			pay = {};
			if ($urandom_range(0, 2) == 0) push_rand(pay, $urandom_range(1, 3));
			put_frame(FT_HEARTBEAT, ch, pay, endb);
		end else if (k < 6) begin
			pay = {};
			pay.push_back(8'd0); pay.push_back(8'd60); push_rand(pay, 2);
			push_rand(pay, 8);
			push_rand(pay, $urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 0);
			if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 12)) void'(pay.pop_back());
			put_frame(FT_HEADER, ch, pay, endb);
		end else begin
			logic [15:0] c, m;
			int trim;
			case ($urandom_range(0, 5))
				0: begin c = CLS_CONNECTION; m = MTH_TUNE; end
				1: begin c = CLS_CONNECTION; m = MTH_OPEN; end
				2: begin c = CLS_BASIC; m = MTH_PUBLISH; end
				3: begin c = CLS_BASIC; m = MTH_DELIVER; end
				4: begin c = CLS_BASIC; m = MTH_ACK; end
				default: begin c = 16'($urandom); m = 16'($urandom); end
			endcase
			trim = ($urandom_range(0, 5) == 0) ? -$urandom_range(1, 6) : $urandom_range(0, 2);
			method_payload(pay, c, m, $urandom_range(0, 6), $urandom_range(0, 6), trim);
			put_frame(FT_METHOD, ch, pay, endb);
		end
	endtask

	initial begin
		logic [7:0] pay[$];
		int burst;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		bytes_sent = 0;

		// Directed: protocol header, each method, extremes and each error kind.
		put_proto();
		method_payload(pay, CLS_CONNECTION, MTH_TUNE, 0, 0, 0);
		pay[4] = 8'hFF; pay[5] = 8'hFF; pay[6] = 8'hFF; pay[11] = 8'hFF;
		put_frame(FT_METHOD, 16'hFFFF, pay, FRAME_END);
		method_payload(pay, CLS_CONNECTION, MTH_OPEN, 255, 0, 0);
		put_frame(FT_METHOD, 16'd0, pay, FRAME_END);
		method_payload(pay, CLS_BASIC, MTH_PUBLISH, 3, 255, 0);
		pay[pay.size() - 1] = 8'hFF;
		put_frame(FT_METHOD, 16'd1, pay, FRAME_END);
		method_payload(pay, CLS_BASIC, MTH_DELIVER, 5, 0, 0);
		for (int i = 0; i < 8; i++) pay[10 + i] = 8'hFF;
		put_frame(FT_METHOD, 16'd2, pay, FRAME_END);
		method_payload(pay, CLS_BASIC, MTH_ACK, 0, 0, 0);
		put_frame(FT_METHOD, 16'd3, pay, FRAME_END);
		method_payload(pay, CLS_BASIC, MTH_ACK, 0, 0, -1);
		put_frame(FT_METHOD, 16'd3, pay, FRAME_END);
		pay = {8'd0, 8'd10};
		put_frame(FT_METHOD, 16'd4, pay, FRAME_END);
		pay = {8'd0, 8'd60, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		put_frame(FT_HEADER, 16'd5, pay, FRAME_END);
		pay = {};
		put_frame(FT_HEARTBEAT, 16'd0, pay, FRAME_END);
		pay = {8'd0};
		put_frame(FT_HEARTBEAT, 16'd0, pay, FRAME_END);
		put_frame(FT_BODY, 16'd7, pay, 8'h00);
		pay = {};
		put_frame(FT_BODY, 16'd7, pay, FRAME_END);
		put_frame(8'hFF, 16'd7, pay, FRAME_END);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_sent < 1200 || stream_bytes.size() != 0) begin
			if (stream_bytes.size() == 0) random_unit(pay);
			burst = $urandom_range(1, 30);
			while (burst > 0 && stream_bytes.size() != 0) begin
				@(posedge clk);
				if (!s_axis_tvalid || s_axis_tready) begin
					if (s_axis_tvalid) begin
						bytes_sent++;
						burst--;
					end
					if (burst > 0) begin
						s_axis_tvalid <= 1'b1;
						s_axis_tdata <= stream_bytes.pop_front();
					end else s_axis_tvalid <= 1'b0;
				end
			end
			// Let the last byte of the burst go through, then sometimes leave a gap.
			while (s_axis_tvalid) begin
				@(posedge clk);
				if (s_axis_tvalid && s_axis_tready) begin
					s_axis_tvalid <= 1'b0;
					bytes_sent++;
				end
			end
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(posedge clk);
		end

		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Fed %0d stream bytes in bursts with gaps and output stalls.", bytes_sent);
		$display("Checked %0d result words, %0d of them with an error status.",
			results_seen, errors_seen);
		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

[amqp_frame_parser.f]
+incdir+rtl
rtl/afp_pkg.sv
rtl/afp_front.sv
rtl/afp_queue.sv
rtl/afp_back.sv
rtl/amqp_frame_parser.sv
rtl/amqp_frame_parser_checker.sv
tb/amqp_frame_parser_checker.sv
tb/tb.sv
